### sv/hfc_pkg.sv
package hfc_pkg;

    // Lookup entry for single to half: magnitude base pattern and mantissa shift
    typedef struct packed {
        logic [14:0] base;
        logic [4:0]  shift;
    } entry_t;

    // Operation codes carried in tuser
    localparam logic OP_S2H = 1'b0;
    localparam logic OP_H2S = 1'b1;

    // Biased single exponent boundaries
    localparam logic [7:0] EX_SUB_LO  = 8'd103;  // unbiased -24
    localparam logic [7:0] EX_NORM_LO = 8'd113;  // unbiased -14
    localparam logic [7:0] EX_NORM_HI = 8'd142;  // unbiased 15
    localparam logic [7:0] EX_MAX     = 8'd255;

    localparam logic [14:0] HALF_INF  = 15'h7C00;
    localparam logic [15:0] HALF_ONE  = 16'h0400;
    localparam logic [4:0]  SH_FLUSH  = 5'd24;
    localparam logic [4:0]  SH_NORM   = 5'd12;

    // Build the table entry for one biased single exponent
    function automatic entry_t lookup(input logic [7:0] ex);
        entry_t     e;
        logic [7:0] d;
        e = '0;
        d = '0;
        if (ex < EX_SUB_LO) begin
            e.base  = '0;
            e.shift = SH_FLUSH;
        end
        else if (ex < EX_NORM_LO) begin
            d       = EX_NORM_LO - ex;
            e.base  = 15'(HALF_ONE >> d);
            e.shift = 5'(8'd125 - ex);
        end
        else if (ex <= EX_NORM_HI) begin
            d       = ex - 8'd112;
            e.base  = {d[4:0], 10'b0};
            e.shift = SH_NORM;
        end
        else if (ex < EX_MAX) begin
            e.base  = HALF_INF;
            e.shift = SH_FLUSH;
        end
        else begin
            e.base  = HALF_INF;
            e.shift = SH_NORM;
        end
        return e;
    endfunction

endpackage

### sv/hfc_table.sv
// Stage one: registered exponent table read, operand held alongside
module hfc_table (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               in_op,
    input  logic [31:0]        in_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               out_op,
    output logic [31:0]        out_value,
    output hfc_pkg::entry_t    out_entry
);

    logic            valid_reg;
    logic            valid_next;
    logic            op_reg;
    logic [31:0]     value_reg;
    hfc_pkg::entry_t entry_reg;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Read the table on load; hold while stalled
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            op_reg    <= in_op;
            value_reg <= in_value;
            entry_reg <= hfc_pkg::lookup(in_value[30:23]);
        end
    end

    assign out_valid = valid_reg;
    assign out_op    = op_reg;
    assign out_value = value_reg;
    assign out_entry = entry_reg;

endmodule

### sv/hfc_format.sv
// Stage two: finish either conversion into the output register
module hfc_format (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               in_op,
    input  logic [31:0]        in_value,
    input  hfc_pkg::entry_t    in_entry,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        out_result
);

    logic        valid_reg;
    logic        valid_next;
    logic [31:0] result_reg;
    logic [31:0] result_next;

    logic [22:0] frac_sh;
    logic [10:0] m11;
    logic [15:0] base16;
    logic [15:0] half;

    logic [4:0]  h_ex;
    logic [9:0]  h_m;
    logic [3:0]  k;
    logic [19:0] norm_w;
    logic [7:0]  sub_ex;
    logic [7:0]  norm_ex;
    logic [31:0] single;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        // single to half: shift, or in the kept bits, add the round bit
        frac_sh = in_value[22:0] >> in_entry.shift;
        m11     = frac_sh[10:0];
        base16  = {in_value[31], in_entry.base};
        half    = (base16 | {6'b0, m11[10:1]}) + {15'b0, m11[0]};

        // half to single
        h_ex = in_value[14:10];
        h_m  = in_value[9:0];
        k    = '0;
        for (int i = 0; i < 10; i++)
        begin
            if (h_m[i])
            begin
                k = 4'(10 - i);
            end
        end
        norm_w  = {10'b0, h_m} << k;
        sub_ex  = 8'd113 - {4'b0, k};
        norm_ex = {3'b0, h_ex} + 8'd112;
        if (h_ex == 5'd0)
        begin
            if (h_m == 10'd0)
            begin
                single = {in_value[15], 31'b0};
            end
            else
            begin
                single = {in_value[15], sub_ex, norm_w[9:0], 13'b0};
            end
        end
        else if (h_ex == 5'h1F)
        begin
            single = {in_value[15], 8'hFF, h_m, 13'b0};
        end
        else
        begin
            single = {in_value[15], norm_ex, h_m, 13'b0};
        end

        result_next = (in_op == hfc_pkg::OP_H2S) ? single : {16'b0, half};

        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

### sv/half_float_convert.sv
// Path: the input is registered in the exponent table stage, then in the format
// stage, and m_tvalid rises once the format stage holds it.
// Throughput: one item per cycle while m_tready stays high; the exponent table read
// and the format stage are each registered, and each stage loads while its successor drains.
// Reset: rst_n asynchronous, active low; clears the stage valid flags only,
// the data registers are not reset.
module half_float_convert (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [0:0]  s_tuser,   // [0] op (0 single to half, 1 half to single)
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] result
);

    // Stage one to stage two handoff
    logic            t_valid;
    logic            t_ready;
    logic            t_op;
    logic [31:0]     t_value;
    hfc_pkg::entry_t t_entry;

    // Stage one: look up base pattern and mantissa shift from the exponent,
    // registered like a synchronous ROM read, with the operand held beside it.
    hfc_table u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser[0]),
        .in_value  (s_tdata),
        .out_valid (t_valid),
        .out_ready (t_ready),
        .out_op    (t_op),
        .out_value (t_value),
        .out_entry (t_entry)
    );

    // Stage two: round and pack the half, or rebuild the single, and hold
    // the item in the output register until the master side takes it.
    // Stage one keeps accepting while that result waits, as long as it is empty.
    hfc_format u_format (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (t_valid),
        .in_ready   (t_ready),
        .in_op      (t_op),
        .in_value   (t_value),
        .in_entry   (t_entry),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (m_tdata)
    );

endmodule

### bench/half_float_convert_test.sv
// Stream test of the single/half precision converter.
// Directed items cover each exponent band of the single to half path: flush to zero,
// subnormal, normal, overflow to infinity, infinity and NaN. They also cover the
// rounding carries and the NaN wrap cases, plus each class of half input. Random
// items follow, weighted toward the interesting exponent bands and toward mantissas
// that make rounding carry. An in-bench conversion function predicts every result,
// and each result is checked in order against the oldest pending prediction.
module half_float_convert_test;

    localparam int WATCHDOG_LIMIT = 5000;  // cycles with no accepted item on either side
    localparam int SETTLE_CYCLES  = 8;     // idle time after the last result; leave slack

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // [31:0] value
    logic [0:0]  s_tuser = '0;   // [0] op (0 single to half, 1 half to single)
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // [31:0] result

    // Idle rates in percent, changed between phases
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    logic [31:0] pending_results[$];
    int unsigned mismatch_count = 0;
    int unsigned stall_cycles = 0;

    half_float_convert u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Conversion predictors
    // ---------------------------------------------------------------

    // Single to half: choose a base pattern and a mantissa shift from the exponent,
    // OR in the top ten kept bits, then add the eleventh as an integer. The carry may
    // ripple through the exponent and wrap out of bit 15 (NaN edge case).
    function automatic logic [31:0] single_to_half(input logic [31:0] w);
        int          e;
        int          sh;
        logic [15:0] base;
        logic [31:0] m11;
        e = int'(w[30:23]) - 127;
        if (e < -24)
        begin
            base = 16'h0000;
            sh   = 24;
        end
        else if (e < -14)
        begin
            base = 16'h0400 >> (-e - 14);
            sh   = -e - 2;
        end
        else if (e <= 15)
        begin
            base = 16'((e + 15) << 10);
            sh   = 12;
        end
        else if (e < 128)
        begin
            // finite overflow: the shift drops every mantissa bit, so no rounding
            base = 16'h7C00;
            sh   = 24;
        end
        else
        begin
            base = 16'h7C00;
            sh   = 12;
        end
        if (w[31])
            base[15] = 1'b1;
        m11 = {9'b0, w[22:0]} >> sh;
        return {16'h0000, 16'((base | 16'(m11 >> 1)) + 16'(m11[0]))};
    endfunction

    // Half to single: rebias normals, normalize subnormals, map exponent 31 to 255.
    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic [31:0] sign_bit;
        logic [31:0] man;
        logic [31:0] wide_man;
        int          k;
        sign_bit = {h[15], 31'b0};
        wide_man = {9'b0, h[9:0], 13'b0};
        if (h[14:10] == 5'd0)
        begin
            if (h[9:0] == 10'd0)
                return sign_bit;
            man = wide_man;
            k   = 0;
            while (!man[23] && k < 10)
            begin
                man = man << 1;
                k++;
            end
            return sign_bit | ((32'h38800000 - 32'(k) * 32'h00800000)
                               | (man & 32'h007FFFFF));
        end
        if (h[14:10] == 5'd31)
            return sign_bit | (32'h47800000 + (32'h38000000 | wide_man));
        return sign_bit | (({27'b0, h[14:10]} << 23) + (32'h38000000 | wide_man));
    endfunction

    function automatic logic [31:0] expected_conversion(input logic op,
                                                        input logic [31:0] value);
        if (op == hfc_pkg::OP_S2H)
            return single_to_half(value);
        return half_to_single(value[15:0]);
    endfunction

    // ---------------------------------------------------------------
    // Stimulus side: call at a falling edge, returns at a falling edge
    // ---------------------------------------------------------------
    task automatic send_item(input logic op, input logic [31:0] value);
        // hold off at random; lower tvalid only while idling
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            s_tuser  <= 1'($urandom_range(1));
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= op;
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(expected_conversion(op, value));
        @(negedge clk);
    endtask

    // Wait for every predicted result, then let the pipeline settle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // ---------------------------------------------------------------
    // Receive side: random backpressure, in-order checking
    // ---------------------------------------------------------------
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result: no item expected, actual %h", m_tdata);
                mismatch_count++;
            end
            else
            begin
                logic [31:0] want;
                want = pending_results.pop_front();
                if (m_tdata !== want)
                begin
                    $error("result: expected %h, actual %h", want, m_tdata);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: count cycles with no handshake on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("half_float_convert: mismatch");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Random item shapes
    // ---------------------------------------------------------------
    function automatic logic [31:0] random_single();
        logic [7:0]  ex;
        logic [22:0] frac;
        logic [7:0]  edge_ex[10];
        int unsigned sel;
        edge_ex = '{8'd0, 8'd102, 8'd103, 8'd104, 8'd112, 8'd113,
                    8'd141, 8'd142, 8'd143, 8'd254};
        sel = $urandom_range(9);
        if (sel < 4)
            ex = 8'($urandom_range(145, 100));       // subnormal and normal bands and their edges
        else if (sel < 6)
            ex = 8'($urandom_range(255));
        else if (sel < 8)
            ex = edge_ex[$urandom_range(9)];
        else
            ex = 8'hFF;                              // infinity and NaN
        case ($urandom_range(3))
            0: frac = 23'($urandom) | 23'h7FE000;    // push rounding carries
            1: frac = 23'($urandom) & 23'h001FFF;    // only the round bit and dropped bits set
            default: frac = 23'($urandom);
        endcase
        return {1'($urandom_range(1)), ex, frac};
    endfunction

    function automatic logic [31:0] random_half();
        logic [4:0] ex;
        case ($urandom_range(3))
            0: ex = 5'd0;
            1: ex = 5'd31;
            default: ex = 5'($urandom_range(31));
        endcase
        // upper half of the word is noise the block must ignore
        return {16'($urandom), 1'($urandom_range(1)), ex, 10'($urandom)};
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_single_to_half_bands();
        send_item(hfc_pkg::OP_S2H, 32'h00000000);  // positive zero
        send_item(hfc_pkg::OP_S2H, 32'h80000000);  // negative zero
        send_item(hfc_pkg::OP_S2H, 32'h33000000);  // just below the subnormal band: flush
        send_item(hfc_pkg::OP_S2H, 32'h33800000);  // smallest half subnormal
        send_item(hfc_pkg::OP_S2H, 32'h387FFFFF);  // top subnormal rounds into normal range
        send_item(hfc_pkg::OP_S2H, 32'h38800000);  // smallest half normal
        send_item(hfc_pkg::OP_S2H, 32'h3F800000);  // one
        send_item(hfc_pkg::OP_S2H, 32'h477FE000);  // largest finite half
        send_item(hfc_pkg::OP_S2H, 32'h477FF000);  // rounding carries into infinity
        send_item(hfc_pkg::OP_S2H, 32'hC7800000);  // first overflow exponent, negative
        send_item(hfc_pkg::OP_S2H, 32'h7F7FFFFF);  // largest finite single: no rounding
        send_item(hfc_pkg::OP_S2H, 32'h7F800000);  // positive infinity
        send_item(hfc_pkg::OP_S2H, 32'hFF800000);  // negative infinity
        send_item(hfc_pkg::OP_S2H, 32'h7FC00000);  // quiet NaN
        send_item(hfc_pkg::OP_S2H, 32'h7F800FFF);  // NaN with kept bits zero turns infinity
        send_item(hfc_pkg::OP_S2H, 32'h7FFFF000);  // positive NaN whose carry wraps
        send_item(hfc_pkg::OP_S2H, 32'hFFFFF000);  // negative NaN whose carry wraps
    endtask

    task automatic test_half_to_single_classes();
        send_item(hfc_pkg::OP_H2S, 32'h00000000);  // positive zero
        send_item(hfc_pkg::OP_H2S, 32'h00008000);  // negative zero
        send_item(hfc_pkg::OP_H2S, 32'h00000001);  // smallest subnormal, deepest normalize
        send_item(hfc_pkg::OP_H2S, 32'hFFFF83FF);  // largest negative subnormal, upper noise
        send_item(hfc_pkg::OP_H2S, 32'h00003C00);  // one
        send_item(hfc_pkg::OP_H2S, 32'h00007BFF);  // largest finite
        send_item(hfc_pkg::OP_H2S, 32'h0000FC00);  // negative infinity
        send_item(hfc_pkg::OP_H2S, 32'hA5A57E01);  // NaN payload kept
    endtask

    task automatic test_random_mix(input int unsigned count);
        logic op;
        repeat (count)
        begin
            op = 1'($urandom_range(1));
            if (op == hfc_pkg::OP_S2H)
                send_item(op, random_single());
            else
                send_item(op, random_half());
        end
    endtask

    // Stop sending until the pipeline is empty, then restart from cold
    task automatic test_pause_until_empty();
        drain_results();
        test_random_mix(20);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // sender rarely idles, receiver stalls about half the time
        send_idle_pct = 8;
        recv_idle_pct = 51;
        test_single_to_half_bands();
        test_half_to_single_classes();
        test_random_mix(430);
        test_pause_until_empty();

        // the other way round
        send_idle_pct = 51;
        recv_idle_pct = 8;
        test_random_mix(440);

        // full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_mix(440);

        drain_results();
        if (mismatch_count == 0)
            $display("half_float_convert: match");
        else
            $display("half_float_convert: mismatch");
        $finish;
    end

endmodule
